### design/lru_key_value_cache_assert.svh
// ---------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property macros for the checker of the LRU key-value cache.
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lkv assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LKV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkv assertion failed in the next cycle");

`endif

### design/lkv_pkg.sv
// ---------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, codes and the lookup decision struct shared by the cache modules.
// ---------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int RANK_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 2;

  localparam logic [APB_AW-1:0] CAP_ADDR  = '0;
  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef logic [ENTRIES-1:0] slot_vec_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [VAL_W-1:0]   value_t;
  typedef logic [RANK_W-1:0]  rank_t;
  typedef logic [CNT_W-1:0]   count_t;

  // Outcome of one lookup, handed from the compare logic to the entry store.
  typedef struct packed {
    logic      hit;
    slot_vec_t match_oh;
    value_t    hit_value;
    rank_t     hit_rank;
    logic      evict;
    slot_vec_t victim_oh;
    slot_vec_t fill_oh;
  } lkv_decision_t;

endpackage

### design/lkv_lookup.sv
// ---------------------------------------------------------------------------
// LRU key-value cache lookup
// Parallel key compare, victim selection and free slot search.
// ---------------------------------------------------------------------------
module lkv_lookup (
  input  logic                  cmd,
  input  lkv_pkg::key_t         key,
  input  lkv_pkg::key_t         entry_key   [lkv_pkg::ENTRIES],
  input  lkv_pkg::value_t       entry_value [lkv_pkg::ENTRIES],
  input  lkv_pkg::rank_t        entry_rank  [lkv_pkg::ENTRIES],
  input  lkv_pkg::slot_vec_t    entry_valid,
  input  lkv_pkg::count_t       entry_count,
  input  logic [lkv_pkg::CAP_W-1:0] capacity,
  output lkv_pkg::lkv_decision_t decision
);
  import lkv_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic [CMP_W-1:0] count_ext;
  logic             put_miss;
  rank_t            oldest_rank;
  slot_vec_t        free_vec;
  lkv_decision_t    dec;

  always_comb begin
    dec = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      dec.match_oh[i] = entry_valid[i] && (entry_key[i] == key);
    end
    dec.hit = |dec.match_oh;

    // Keys are unique among valid slots, so an OR of the matching slot is a mux.
    for (int i = 0; i < ENTRIES; i++) begin
      if (dec.match_oh[i]) begin
        dec.hit_value = dec.hit_value | entry_value[i];
        dec.hit_rank  = dec.hit_rank | entry_rank[i];
      end
    end

    cap_ext   = CMP_W'(capacity);
    count_ext = CMP_W'(entry_count);
    priority if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end

    put_miss  = (cmd == CMD_PUT) && !dec.hit;
    dec.evict = put_miss && (entry_count != '0) && (count_ext >= cap_eff);

    // Valid ranks are exactly 0 .. count-1, so the oldest slot holds count-1.
    oldest_rank = RANK_W'(entry_count - CNT_W'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      dec.victim_oh[i] = dec.evict && entry_valid[i] && (entry_rank[i] == oldest_rank);
    end

    // Lowest free slot after the eviction.
    free_vec    = ~(entry_valid & ~dec.victim_oh);
    dec.fill_oh = put_miss ? (free_vec & slot_vec_t'(~free_vec + slot_vec_t'(1))) : '0;
  end

  assign decision = dec;

endmodule

### design/lkv_entries.sv
// ---------------------------------------------------------------------------
// LRU key-value cache entry store
// Slot keys, values, valid bits, recency ranks and the fill count.
// ---------------------------------------------------------------------------
module lkv_entries (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   upd_valid,
  input  logic                   cmd,
  input  lkv_pkg::key_t          key,
  input  lkv_pkg::value_t        value,
  input  lkv_pkg::lkv_decision_t decision,
  output lkv_pkg::key_t          entry_key   [lkv_pkg::ENTRIES],
  output lkv_pkg::value_t        entry_value [lkv_pkg::ENTRIES],
  output lkv_pkg::rank_t         entry_rank  [lkv_pkg::ENTRIES],
  output lkv_pkg::slot_vec_t     entry_valid,
  output lkv_pkg::count_t        entry_count
);
  import lkv_pkg::*;

  logic put_miss;
  logic put_hit;

  assign put_miss = upd_valid && (cmd == CMD_PUT) && !decision.hit;
  assign put_hit  = upd_valid && (cmd == CMD_PUT) && decision.hit;

  // Control state: valid bits, ranks and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else if (upd_valid) begin
      if (put_miss) begin
        entry_count <= entry_count - CNT_W'(decision.evict) + CNT_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (decision.fill_oh[i]) begin
            entry_valid[i] <= 1'b1;
            entry_rank[i]  <= '0;
          end else if (decision.victim_oh[i]) begin
            entry_valid[i] <= 1'b0;
            entry_rank[i]  <= '0;
          end else if (entry_valid[i]) begin
            entry_rank[i] <= entry_rank[i] + RANK_W'(1);
          end
        end
      end else if (decision.hit) begin
        // Promote the hit slot; more recent slots move back by one.
        for (int i = 0; i < ENTRIES; i++) begin
          if (decision.match_oh[i]) begin
            entry_rank[i] <= '0;
          end else if (entry_valid[i] && (entry_rank[i] < decision.hit_rank)) begin
            entry_rank[i] <= entry_rank[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  // Payload: no reset, only read while the slot is valid.
  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (put_miss && decision.fill_oh[i]) begin
        entry_key[i]   <= key;
        entry_value[i] <= value;
      end else if (put_hit && decision.match_oh[i]) begin
        entry_value[i] <= value;
      end
    end
  end

endmodule

### design/lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// LRU key-value cache
// Sixteen-slot fully associative key-value store with LRU replacement.
// ---------------------------------------------------------------------------
// A request transfer is captured in the request register, looked up and applied
// there, and its result, with done high, is captured in the result register.
// Throughput: one request per cycle; busy stays low, set by the single lookup
// and update pass between the request register and the result register.
// Reset clears all valid bits, ranks and the fill count, and sets
// capacity to 16. The receiver cannot stall, so no result is held.
module lru_key_value_cache (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic signed [lkv_pkg::KEY_W-1:0] key,
  input  logic signed [lkv_pkg::VAL_W-1:0] value,
  output logic                             done,
  output logic                             hit,
  output logic signed [lkv_pkg::VAL_W-1:0] read_value,
  output logic                             evicted,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lkv_pkg::APB_AW-1:0]       paddr,
  input  logic [lkv_pkg::APB_DW-1:0]       pwdata,
  output logic [lkv_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);
  import lkv_pkg::*;

  // Request register: the item being looked up this cycle.
  logic             in_valid;
  logic             in_cmd;
  key_t             in_key;
  value_t           in_value;

  // Configuration register.
  logic [CAP_W-1:0] capacity;

  // Entry state.
  key_t             entry_key   [ENTRIES];
  value_t           entry_value [ENTRIES];
  rank_t            entry_rank  [ENTRIES];
  slot_vec_t        entry_valid;
  count_t           entry_count;

  lkv_decision_t    decision;
  value_t           read_value_next;

  // Every cycle can take a new request: the lookup and the state update of
  // the previous request finish in the same cycle it sits in the register.
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = APB_DW'(capacity);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == CAP_ADDR)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Capture a request transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd   <= cmd;
      in_key   <= key;
      in_value <= value;
    end
  end

  lkv_lookup u_lookup (
    .cmd         (in_cmd),
    .key         (in_key),
    .entry_key   (entry_key),
    .entry_value (entry_value),
    .entry_rank  (entry_rank),
    .entry_valid (entry_valid),
    .entry_count (entry_count),
    .capacity    (capacity),
    .decision    (decision)
  );

  lkv_entries u_entries (
    .clk         (clk),
    .rst         (rst),
    .upd_valid   (in_valid),
    .cmd         (in_cmd),
    .key         (in_key),
    .value       (in_value),
    .decision    (decision),
    .entry_key   (entry_key),
    .entry_value (entry_value),
    .entry_rank  (entry_rank),
    .entry_valid (entry_valid),
    .entry_count (entry_count)
  );

  // Only a get that hits returns stored data; everything else reads all ones.
  assign read_value_next = ((in_cmd == CMD_GET) && decision.hit) ? decision.hit_value : '1;

  // Result register: one transfer per request, shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      hit        <= decision.hit;
      read_value <= read_value_next;
      evicted    <= decision.evict;
    end
  end

endmodule

### design/lkv_checker.sv
// ---------------------------------------------------------------------------
// LRU key-value cache checker
// Port-level properties of the cache, bound to the top level.
// ---------------------------------------------------------------------------
`include "lru_key_value_cache_assert.svh"

module lkv_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic                             hit,
  input logic signed [lkv_pkg::VAL_W-1:0] read_value,
  input logic                             evicted,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic [lkv_pkg::APB_AW-1:0]       paddr,
  input logic [lkv_pkg::APB_DW-1:0]       pwdata,
  input logic [lkv_pkg::APB_DW-1:0]       prdata
);
  import lkv_pkg::*;

  // Each request transfer gives exactly one result transfer, through the request and result registers.
  `LKV_ASSERT_SAME(a_one_result, clk, rst, !$past(rst) && !$past(rst, 2), done == $past(start && !busy, 2))

  // An eviction only happens on a put of a new key.
  `LKV_ASSERT_SAME(a_evict_is_miss, clk, rst, done && evicted, !hit && (read_value == '1))

  // A miss never returns stored data.
  `LKV_ASSERT_SAME(a_miss_all_ones, clk, rst, done && !hit, read_value == '1)

  // A capacity write reads back in the next cycle.
  `LKV_ASSERT_NEXT(a_cap_readback, clk, rst, psel && penable && pwrite && (paddr == CAP_ADDR), prdata == APB_DW'($past(pwdata[CAP_W-1:0])))

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

### verif/tb_lru_key_value_cache.sv
// ---------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives get and put transfers into the cache and predicts each result with a
// shadow copy of the slots and their recency ranks. Every result strobe is
// checked field by field against the oldest prediction. A directed table
// covers key and value extremes and capacity corner cases. Random phases
// follow, each with its own capacity setting and sender idle rate.
// ---------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lkv_pkg::*;

  // Value returned on a get miss and on every put.
  localparam value_t MISS_VALUE = '1;

  typedef struct packed {
    logic   hit;
    value_t read_value;
    logic   evicted;
  } lookup_result_t;

  // One row of the directed table. When set_cap is high, the capacity
  // register is rewritten (with the cache drained) before the request goes
  // out. Rows with fixed high carry their own expected result; all other
  // rows are checked against the shadow cache.
  typedef struct packed {
    logic             set_cap;
    logic [CAP_W-1:0] cap;
    cmd_t             op;
    key_t             k;
    value_t           v;
    logic             fixed;
    lookup_result_t   want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                cmd;
  key_t                key;
  value_t              value;
  logic                done;
  logic                hit;
  value_t              read_value;
  logic                evicted;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Shadow copy of the cache contents, used to predict each result.
  key_t             shadow_key  [ENTRIES];
  value_t           shadow_val  [ENTRIES];
  logic             shadow_vld  [ENTRIES];
  rank_t            shadow_rank [ENTRIES];
  count_t           shadow_fill;
  logic [CAP_W-1:0] shadow_cap;

  lookup_result_t   pending_results[$];
  stim_row_t        dir_rows[$];
  int               mismatch_count;

  lru_key_value_cache u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .key        (key),
    .value      (value),
    .done       (done),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The run ends here if the cache stops producing results or keeps busy high.
  initial begin
    #5_000_000;
    $display("tb_lru_key_value_cache NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("mismatch: %s expected %h got %h at %0t", what, want, got, $time);
    end
  endtask

  // Move slot s to rank 0. Valid slots that were more recent than s age by
  // one, so the valid ranks stay a dense set starting at zero.
  function automatic void make_newest(input int s);
    rank_t r;
    r = shadow_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_vld[i] && shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[s] = '0;
  endfunction

  // Apply one request to the shadow cache and return the result it causes.
  function automatic lookup_result_t lru_lookup(input cmd_t op, input key_t k,
                                                input value_t v);
    lookup_result_t r;
    int             match;
    int             oldest;
    int             slot;
    int             cap_eff;
    r.hit        = 1'b0;
    r.read_value = MISS_VALUE;
    r.evicted    = 1'b0;
    match        = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_vld[i] && shadow_key[i] == k) match = i;
    end
    if (match >= 0) r.hit = 1'b1;
    if (op == CMD_GET) begin
      if (match >= 0) begin
        r.read_value = shadow_val[match];
        make_newest(match);
      end
    end else if (match >= 0) begin
      shadow_val[match] = v;
      make_newest(match);
    end else begin
      // A capacity of zero acts as one, and anything above the slot count
      // saturates. When the capacity was lowered below the fill level, only
      // one entry goes per new key, so the fill level does not shrink.
      cap_eff = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : int'(shadow_cap));
      if (shadow_fill >= cap_eff && shadow_fill > 0) begin
        oldest = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_vld[i] && (oldest < 0 || shadow_rank[i] > shadow_rank[oldest])) oldest = i;
        end
        shadow_vld[oldest]  = 1'b0;
        shadow_rank[oldest] = '0;
        shadow_fill--;
        r.evicted = 1'b1;
      end
      // The new key goes into the lowest free slot as the most recent entry.
      slot = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
        if (!shadow_vld[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (shadow_vld[i]) shadow_rank[i]++;
        end
        shadow_key[slot]  = k;
        shadow_val[slot]  = v;
        shadow_vld[slot]  = 1'b1;
        shadow_rank[slot] = '0;
        shadow_fill++;
      end
    end
    return r;
  endfunction

  // Present one request and hold it until the cache takes the transfer. The
  // prediction is queued at the accepting edge, ahead of the result.
  // start is left high so that a following request can go out back to back.
  task automatic issue_request(input cmd_t op, input key_t k, input value_t v,
                               input logic fixed, input lookup_result_t want);
    lookup_result_t pred;
    start <= 1'b1;
    cmd   <= op;
    key   <= k;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    pred = lru_lookup(op, k, v);
    pending_results.push_back(fixed ? want : pred);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  // Every request causes exactly one result, so an empty queue means idle.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register over the configuration port and read it
  // back. The upper data bits are random; only the low five bits are kept.
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    logic [APB_DW-1:0] wd;
    wd = {(APB_DW - CAP_W)'($urandom()), c};
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    shadow_cap = c;
    // Go straight from the write access into the setup of the read.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {{(APB_DW - CAP_W){1'b0}}, c}) begin
      report_mismatch("capacity readback", {{(APB_DW - CAP_W){1'b0}}, c}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input logic sc, input logic [CAP_W-1:0] c, input cmd_t op,
                         input key_t k, input value_t v, input logic fx,
                         input logic h, input value_t rd, input logic ev);
    stim_row_t r;
    r.set_cap         = sc;
    r.cap             = c;
    r.op              = op;
    r.k               = k;
    r.v               = v;
    r.fixed           = fx;
    r.want.hit        = h;
    r.want.read_value = rd;
    r.want.evicted    = ev;
    dir_rows.push_back(r);
  endtask

  // Each result strobe lasts one cycle and cannot be held off, so it is
  // sampled at the edge that ends that cycle and matched to the oldest
  // prediction.
  always @(posedge clk) begin
    lookup_result_t w;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 32'd0, 32'd1);
      end else begin
        w = pending_results.pop_front();
        if (hit !== w.hit) report_mismatch("hit", 32'(w.hit), 32'(hit));
        if (read_value !== w.read_value) report_mismatch("read_value", w.read_value, read_value);
        if (evicted !== w.evicted) report_mismatch("evicted", 32'(w.evicted), 32'(evicted));
      end
    end
  end

  initial begin
    int               phase_cap  [8];
    int               phase_idle [8];
    key_t             key_pool[$];
    key_t             k;
    logic [CAP_W-1:0] cap;
    int               eff;

    mismatch_count = 0;
    rst     <= 1'b1;
    start   <= 1'b0;
    cmd     <= CMD_GET;
    key     <= '0;
    value   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_key[i]  = '0;
      shadow_val[i]  = '0;
      shadow_vld[i]  = 1'b0;
      shadow_rank[i] = '0;
    end
    shadow_fill = '0;
    shadow_cap  = CAP_RESET;

    // Directed part. The first rows run with the reset capacity of sixteen
    // and exercise key and value extremes, hits, misses, and overwrites.
    add_row(0, 0, CMD_GET, 32'h0000_0000, 32'h1234_5678, 1, 0, MISS_VALUE, 0);
    add_row(0, 0, CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, MISS_VALUE, 0);
    add_row(0, 0, CMD_GET, 32'h8000_0000, 32'hDEAD_BEEF, 1, 1, 32'h7FFF_FFFF, 0);
    add_row(0, 0, CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, MISS_VALUE, 0);
    add_row(0, 0, CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1, 1, 32'h8000_0000, 0);
    add_row(0, 0, CMD_PUT, 32'h8000_0000, 32'h0000_0000, 1, 1, MISS_VALUE, 0);
    add_row(0, 0, CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1, 1, 32'h0000_0000, 0);
    add_row(0, 0, CMD_GET, 32'h0000_0000, 32'h0000_0000, 1, 0, MISS_VALUE, 0);
    add_row(0, 0, CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, MISS_VALUE, 0);
    add_row(0, 0, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1, MISS_VALUE, 0);
    add_row(0, 0, CMD_GET, 32'h7FFF_FFFE, 32'h0000_0000, 1, 0, MISS_VALUE, 0);
    // Capacity lowered to one while three entries are held: each new key
    // evicts only the oldest entry, while hits and overwrites evict nothing.
    add_row(1, 5'd1,  CMD_PUT, 32'h0000_0005, 32'h0000_0055, 0, 0, 0, 0);
    add_row(0, 0,     CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 0, 0, 0, 0);
    add_row(0, 0,     CMD_PUT, 32'h0000_0006, 32'h0000_0066, 0, 0, 0, 0);
    add_row(0, 0,     CMD_PUT, 32'h0000_0006, 32'h0000_0067, 0, 0, 0, 0);
    add_row(0, 0,     CMD_GET, 32'h0000_0006, 32'h0000_0000, 0, 0, 0, 0);
    // A capacity of zero behaves like a capacity of one.
    add_row(1, 5'd0,  CMD_PUT, 32'h0000_0007, 32'hA5A5_A5A5, 0, 0, 0, 0);
    add_row(0, 0,     CMD_GET, 32'h0000_0007, 32'h0000_0000, 0, 0, 0, 0);
    // The largest register value saturates to the slot count.
    add_row(1, 5'd31, CMD_PUT, 32'h0000_0008, 32'h5A5A_5A5A, 0, 0, 0, 0);
    add_row(0, 0,     CMD_PUT, 32'h0000_0009, 32'h0F0F_0F0F, 0, 0, 0, 0);
    add_row(1, 5'd2,  CMD_PUT, 32'h0000_000A, 32'hF0F0_F0F0, 0, 0, 0, 0);
    add_row(0, 0,     CMD_GET, 32'h0000_000A, 32'h0000_0000, 0, 0, 0, 0);
    add_row(1, 5'd16, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0, 0);

    // Random phases: capacity setting and sender idle rate per phase. The
    // last phase picks any register value.
    phase_cap  = '{16, 1, 31, 0, 5, 2, 16, 0};
    phase_idle = '{0, 50, 7, 0, 50, 7, 50, 0};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cap) set_capacity(dir_rows[i].cap);
      issue_request(dir_rows[i].op, dir_rows[i].k, dir_rows[i].v, dir_rows[i].fixed,
                    dir_rows[i].want);
    end

    for (int p = 0; p < 8; p++) begin
      cap = (p == 7) ? CAP_W'($urandom_range(0, 31)) : CAP_W'(phase_cap[p]);
      set_capacity(cap);
      // Keys come mostly from a pool a little larger than the capacity, so
      // the phase sees a steady mix of hits, misses, and evictions.
      eff = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : int'(cap));
      key_pool.delete();
      key_pool.push_back(32'h8000_0000);
      key_pool.push_back(32'h7FFF_FFFF);
      repeat (eff + $urandom_range(0, 6)) key_pool.push_back($urandom());
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(0, 99) < phase_idle[p]) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else k = $urandom();
        issue_request(cmd_t'($urandom_range(0, 1)), k, $urandom(), 1'b0, '0);
      end
    end

    // Let the last results drain, then wait on for any stray strobe to show up.
    wait_idle();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never arrived", pending_results.size(), 32'd0);
    end
    if (mismatch_count == 0) begin
      $display("tb_lru_key_value_cache OK");
    end else begin
      $display("tb_lru_key_value_cache NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/lkv_pkg.sv
design/lkv_lookup.sv
design/lkv_entries.sv
design/lru_key_value_cache.sv
design/lkv_checker.sv
verif/tb_lru_key_value_cache.sv
